// ===== design/sstt_pkg.sv =====
// shared types, constants and helper functions for the seven-segment formatter
// no dependencies; imported by every module of the block
package sstt_pkg;

	// reciprocal multipliers for exact constant division
	localparam logic [16:0] MinRecip  = 17'd69906;   // /240, shift 24
	localparam logic [20:0] FRecip    = 21'd1342178; // /50, shift 26
	localparam logic [15:0] CRecip    = 16'd52429;   // /10, shift 19
	localparam logic [12:0] Q10Recip  = 13'd6554;    // /10, shift 16
	localparam logic [10:0] Q2Recip   = 11'd1639;    // /10, shift 14, exact below 1183
	localparam logic [8:0]  HourRecip = 9'd274;      // /60, shift 14
	localparam logic [7:0]  SmallRecip = 8'd205;     // /10, shift 11

	localparam logic [15:0] TicksMin  = 16'd240;
	localparam logic [15:0] TicksHour = 16'd14400;
	localparam logic [13:0] FOffset   = 14'd32;

	localparam logic [7:0] SegColon = 8'h80;
	localparam logic [7:0] SegC     = 8'h39;
	localparam logic [7:0] SegF     = 8'h71;
	localparam logic [7:0] SegBlank = 8'h00;

	typedef enum logic [1:0] {
		TM_SEC,
		TM_MIN,
		TM_HOUR
	} tmode_t;

	typedef enum logic {
		OP_TIMER = 1'b0,
		OP_TEMP  = 1'b1
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        unit;
		tmode_t      mode;
		logic [15:0] value;
		logic [8:0]  mins;
		logic [13:0] temp;
	} s1_t;

	typedef struct packed {
		op_t         op;
		logic        unit;
		tmode_t      mode;
		logic [2:0]  hrs;
		logic [5:0]  secs;
		logic [8:0]  mins;
		logic [10:0] q1;
		logic [3:0]  d0;
	} s2_t;

	typedef struct packed {
		op_t        op;
		logic       unit;
		tmode_t     mode;
		logic [5:0] left;
		logic [5:0] right;
		logic [6:0] q2;
		logic [3:0] d1;
		logic [3:0] d0;
	} s3_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'd0: g = 8'h3F;
			4'd1: g = 8'h06;
			4'd2: g = 8'h5B;
			4'd3: g = 8'h4F;
			4'd4: g = 8'h66;
			4'd5: g = 8'h6D;
			4'd6: g = 8'h7D;
			4'd7: g = 8'h07;
			4'd8: g = 8'h7F;
			4'd9: g = 8'h6F;
			default: g = SegBlank;
		endcase
		return g;
	endfunction

	// x / 10 for any 7-bit x
	function automatic logic [3:0] tens_of(input logic [6:0] x);
		logic [14:0] p;
		p = 15'(x) * 15'(SmallRecip);
		return p[14:11];
	endfunction

endpackage

// ===== design/sstt_quot.sv =====
// stage 1: total minutes and whole temperature by reciprocal multiplication
// depends on sstt_pkg
module sstt_quot (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic                 in_op,
	input  logic [15:0]          in_value,
	input  logic                 unit,
	output logic                 valid_s1,
	output sstt_pkg::s1_t        data_s1
);
	import sstt_pkg::*;

	logic [32:0] min_prod;
	logic [19:0] n9;
	logic [40:0] f_prod;
	logic [34:0] c_prod;
	logic [13:0] f_val;
	s1_t         nxt;

	always_comb begin
		min_prod = 33'(in_value) * 33'(MinRecip);
		n9       = {1'b0, in_value, 3'b000} + 20'(in_value);
		f_prod   = 41'(n9) * 41'(FRecip);
		c_prod   = 35'(in_value) * 35'(CRecip);
		f_val    = f_prod[39:26] + FOffset;

		nxt.op    = op_t'(in_op);
		nxt.unit  = unit;
		nxt.value = in_value;
		nxt.mins  = min_prod[32:24];
		nxt.temp  = unit ? f_val : c_prod[32:19];
		if (in_value < TicksMin) begin
			nxt.mode = TM_SEC;
		end else if (in_value < TicksHour) begin
			nxt.mode = TM_MIN;
		end else begin
			nxt.mode = TM_HOUR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== design/sstt_digits.sv =====
// stages 2 and 3: hours, seconds and decimal digit extraction
// depends on sstt_pkg
module sstt_digits (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_s1,
	input  sstt_pkg::s1_t   data_s1,
	output logic            valid_s3,
	output sstt_pkg::s3_t   data_s3
);
	import sstt_pkg::*;

	logic        valid_s2;
	s2_t         data_s2;
	s2_t         nxt2;
	s3_t         nxt3;
	logic [17:0] h_prod;
	logic [15:0] rem_ticks;
	logic [26:0] q1_prod;
	logic [13:0] d0_full;
	logic [8:0]  min_hr;
	logic [21:0] q2_prod;
	logic [10:0] d1_full;

	always_comb begin
		h_prod    = 18'(data_s1.mins) * 18'(HourRecip);
		rem_ticks = data_s1.value - ((16'(data_s1.mins) << 8) - (16'(data_s1.mins) << 4));
		q1_prod   = 27'(data_s1.temp) * 27'(Q10Recip);
		d0_full   = data_s1.temp - ({3'b000, q1_prod[26:16]} * 14'd10);

		nxt2.op   = data_s1.op;
		nxt2.unit = data_s1.unit;
		nxt2.mode = data_s1.mode;
		nxt2.hrs  = h_prod[16:14];
		nxt2.secs = rem_ticks[7:2];
		nxt2.mins = data_s1.mins;
		nxt2.q1   = q1_prod[26:16];
		nxt2.d0   = d0_full[3:0];
	end

	always_comb begin
		min_hr  = data_s2.mins - (9'(data_s2.hrs) * 9'd60);
		q2_prod = 22'(data_s2.q1) * 22'(Q2Recip);
		d1_full = data_s2.q1 - ({4'b0000, q2_prod[20:14]} * 11'd10);

		nxt3.op   = data_s2.op;
		nxt3.unit = data_s2.unit;
		nxt3.mode = data_s2.mode;
		// hours:minutes past the hour, else minutes:seconds
		if (data_s2.mode == TM_HOUR) begin
			nxt3.left  = 6'(data_s2.hrs);
			nxt3.right = min_hr[5:0];
		end else begin
			nxt3.left  = data_s2.mins[5:0];
			nxt3.right = data_s2.secs;
		end
		nxt3.q2 = q2_prod[20:14];
		nxt3.d1 = d1_full[3:0];
		nxt3.d0 = data_s2.d0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt2;
			data_s3 <= nxt3;
		end
	end

endmodule

// ===== design/sstt_seg.sv =====
// stage 4: final digit split, blanking and segment encoding into the output register
// depends on sstt_pkg
module sstt_seg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_s3,
	input  sstt_pkg::s3_t   data_s3,
	output logic            valid_s4,
	output logic [31:0]     data_s4
);
	import sstt_pkg::*;

	logic [3:0] lt;
	logic [3:0] lo;
	logic [3:0] rt;
	logic [3:0] ro;
	logic [3:0] q3;
	logic [6:0] d2_full;
	logic [5:0] lo_full;
	logic [5:0] ro_full;
	logic [7:0] dig1;
	logic [7:0] dig2;
	logic [7:0] dig3;
	logic [7:0] dig4;

	always_comb begin
		lt      = tens_of(7'(data_s3.left));
		rt      = tens_of(7'(data_s3.right));
		lo_full = data_s3.left - (6'(lt) * 6'd10);
		ro_full = data_s3.right - (6'(rt) * 6'd10);
		lo      = lo_full[3:0];
		ro      = ro_full[3:0];
		q3      = tens_of(data_s3.q2);
		d2_full = data_s3.q2 - (7'(q3) * 7'd10);

		if (data_s3.op == OP_TEMP) begin
			dig1 = (d2_full[3:0] == 4'd0) ? SegBlank : glyph(d2_full[3:0]);
			dig2 = glyph(data_s3.d1);
			dig3 = glyph(data_s3.d0);
			dig4 = data_s3.unit ? SegF : SegC;
		end else begin
			// in minutes mode, leading minute digit blank under ten minutes
			if (data_s3.mode == TM_MIN && data_s3.left < 6'd10) begin
				dig1 = SegBlank;
			end else begin
				dig1 = glyph(lt);
			end
			dig2 = glyph(lo) | SegColon;
			dig3 = glyph(rt);
			dig4 = glyph(ro);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s4 <= {dig4, dig3, dig2, dig1};
		end
	end

endmodule

// ===== design/seven_segment_time_temp_formatter.sv =====
// top level of the seven-segment time / temperature formatter
// depends on sstt_pkg, sstt_quot, sstt_digits, sstt_seg
//
//  channel   direction  handshake                        payload
//  s_axis    in         s_axis_tvalid / s_axis_tready    tdata value, tuser op
//  m_axis    out        m_axis_tvalid / m_axis_tready    tdata four segment bytes
//  cfg       in         cfg_valid / cfg_ready            cfg_data temp_unit
//
// four register stages; an input transaction passes through s1, s2 and s3 and its
// result becomes valid in s4; one transaction is taken every cycle while the
// output is drained.
// the whole pipeline holds when the output register is full and not taken, so while
// it is full s_axis_tready follows m_axis_tready in the same cycle.
// reset clears all valid bits and sets temp_unit to celsius; cfg is always ready.
module seven_segment_time_temp_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] value
	input  logic        s_axis_tuser,   // [0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] seg_digit1, [15:8] seg_digit2,
	                                    // [23:16] seg_digit3, [31:24] seg_digit4
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data        // [0] temp_unit
);
	import sstt_pkg::*;

	logic  en;
	logic  temp_unit_q;
	logic  valid_s1;
	s1_t   data_s1;
	logic  valid_s3;
	s3_t   data_s3;
	logic  valid_s4;

	assign en            = !valid_s4 || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_unit_q <= 1'b0;
		end else if (cfg_valid) begin
			temp_unit_q <= cfg_data;
		end
	end

	sstt_quot u_quot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_value (s_axis_tdata),
		.unit     (temp_unit_q),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	sstt_digits u_digits (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	sstt_seg u_seg (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.valid_s4 (valid_s4),
		.data_s4  (m_axis_tdata)
	);

endmodule
